FILE: design/orot_pkg.sv
// ----------------------------------------------------------------------------
// orot_pkg: shared types and constants of the rectangle overlap test
// Fixed trig pipeline depth, queue depth, series divisors with their
// reciprocals, and the queue status word.
// ----------------------------------------------------------------------------
`default_nettype none

package orot_pkg;

  // trig pipeline: fold, angle scale, square, four series steps, round
  localparam int unsigned TRIG_LAT   = 16;
  localparam int unsigned NSTEP      = 4;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] ROUND_Q16   = 32'h0000_2000;
  localparam logic [17:0] Q16_ONE     = 18'h1_0000;
  localparam logic [63:0] TWO_POW32   = 64'h1_0000_0000;

  // Horner divisors, innermost term first; the last sine step only multiplies by x
  localparam logic [6:0] SIN_DIV [NSTEP] = '{7'd42, 7'd20, 7'd6, 7'd1};
  localparam logic [6:0] COS_DIV [NSTEP] = '{7'd56, 7'd30, 7'd12, 7'd2};

  // floor(2^32 / d), an estimate at most one low for 30-bit dividends; zero for the last sine step
  localparam logic [31:0] SIN_RCP [NSTEP] = '{
    32'(TWO_POW32 / 64'd42), 32'(TWO_POW32 / 64'd20), 32'(TWO_POW32 / 64'd6), 32'd0};
  localparam logic [31:0] COS_RCP [NSTEP] = '{
    32'(TWO_POW32 / 64'd56), 32'(TWO_POW32 / 64'd30), 32'(TWO_POW32 / 64'd12),
    32'(TWO_POW32 / 64'd2)};

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

FILE: design/orot_fifo.sv
// ----------------------------------------------------------------------------
// orot_fifo: short word queue between front and back
// Registered count gives full and empty; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module orot_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [W-1:0]      data_i,
  input  wire logic              pop_i,
  output      logic [W-1:0]      data_o,
  output      orot_pkg::fifo_stat_t stat_o
);
  import orot_pkg::*;

  localparam int unsigned PTRW = $clog2(FIFO_DEPTH);
  localparam logic [PTRW:0] DEPTH_C = (PTRW+1)'(FIFO_DEPTH);

  logic [W-1:0]    mem_q [FIFO_DEPTH];
  logic [PTRW-1:0] wptr_q, rptr_q;
  logic [PTRW:0]   cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == DEPTH_C);
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C) else $error("queue count beyond depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

FILE: design/orot_front.sv
// ----------------------------------------------------------------------------
// orot_front: input stage
// Register a rectangle pair, form centre differences and the angle difference,
// and hand the word to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module orot_front #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned WW = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] a_center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] a_center_y_i,
  input  wire logic        [COORD_WIDTH-2:0] a_half_w_i,
  input  wire logic        [COORD_WIDTH-2:0] a_half_h_i,
  input  wire logic        [ANGLE_WIDTH-1:0] a_angle_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_center_y_i,
  input  wire logic        [COORD_WIDTH-2:0] b_half_w_i,
  input  wire logic        [COORD_WIDTH-2:0] b_half_h_i,
  input  wire logic        [ANGLE_WIDTH-1:0] b_angle_i,
  input  wire orot_pkg::fifo_stat_t          stat_i,
  output      logic                          push_o,
  output      logic [WW-1:0]                 word_o
);
  import orot_pkg::*;

  localparam int unsigned DXW = COORD_WIDTH + 1;

  logic              valid_q;
  logic [WW-1:0]     word_q;
  logic signed [DXW-1:0] dx, dy;
  logic [ANGLE_WIDTH-1:0] dang;
  logic              take;

  assign in_ready_o = !valid_q || !stat_i.full;
  assign push_o     = valid_q && !stat_i.full;
  assign take       = in_valid_i && in_ready_o;
  assign word_o     = word_q;

  assign dx   = DXW'(b_center_x_i) - DXW'(a_center_x_i);
  assign dy   = DXW'(b_center_y_i) - DXW'(a_center_y_i);
  assign dang = b_angle_i - a_angle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take || (valid_q && !push_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= {dx, dy, a_half_w_i, a_half_h_i, b_half_w_i, b_half_h_i,
                 a_angle_i, b_angle_i, dang};
    end
  end

endmodule

`default_nettype wire

FILE: design/orot_trig.sv
// ----------------------------------------------------------------------------
// orot_trig: pipelined cosine and sine of a turn fraction
// Fold to an octant, scale to Q30 radians, Horner Taylor series with exact
// constant division, round to Q16 and unfold the quadrant.
// ----------------------------------------------------------------------------
`default_nettype none

module orot_trig #(
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [ANGLE_WIDTH-1:0] angle_i,
  output      logic signed [17:0]     cos_o,
  output      logic signed [17:0]     sin_o
);
  import orot_pkg::*;

  localparam int unsigned TW = ANGLE_WIDTH - 2;
  localparam logic [TW-1:0] HALF_Q = TW'(1) << (ANGLE_WIDTH - 3);
  localparam int unsigned NCX = 3 * NSTEP + 1;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
  } trig_carry_t;

  // fold
  logic [TW-1:0] r0, t0;
  logic          sw0;
  logic [TW-1:0] t_q;
  logic [1:0]    q0_q, q1_q;
  logic          sw0_q, sw1_q;
  logic [29:0]   x1_q;
  logic [TW+30:0] prod_x;
  logic [59:0]   prod_x2;
  trig_carry_t   cx_q [NCX];

  assign r0  = angle_i[TW-1:0];
  assign sw0 = (r0 > HALF_Q);
  assign t0  = sw0 ? (TW'(0) - r0) : r0;

  assign prod_x  = (TW+31)'(t_q) * (TW+31)'(HALF_PI_Q30);
  assign prod_x2 = 60'(x1_q) * 60'(x1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= t0;
      q0_q  <= angle_i[ANGLE_WIDTH-1 -: 2];
      sw0_q <= sw0;
      x1_q  <= prod_x[TW+29:TW];
      q1_q  <= q0_q;
      sw1_q <= sw0_q;
      cx_q[0] <= '{quad: q1_q, swap: sw1_q, x: x1_q, x2: prod_x2[59:30]};
      for (int j = 1; j < NCX; j++) begin
        cx_q[j] <= cx_q[j-1];
      end
    end
  end

  // series steps: multiply, reciprocal estimate, correct and subtract from one
  logic [29:0] mn_s_q [NSTEP], mn_c_q [NSTEP];
  logic [29:0] an_s_q [NSTEP], an_c_q [NSTEP];
  logic [29:0] aq_s_q [NSTEP], aq_c_q [NSTEP];
  logic [30:0] bp_s_q [NSTEP], bp_c_q [NSTEP];
  logic [29:0] bn_s_q [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic [30:0] p_s, p_c;
    logic [29:0] mul_s;
    logic [60:0] pm_s, pm_c;
    logic [61:0] pq_s, pq_c;
    logic [30:0] r_s, r_c;
    logic [29:0] q_s, q_c;

    if (k == 0) begin : g_first
      assign p_s = Q30_ONE;
      assign p_c = Q30_ONE;
    end else begin : g_next
      assign p_s = bp_s_q[k-1];
      assign p_c = bp_c_q[k-1];
    end

    assign mul_s = (k == NSTEP - 1) ? cx_q[3*k].x : cx_q[3*k].x2;
    assign pm_s  = 61'(mul_s) * 61'(p_s);
    assign pm_c  = 61'(cx_q[3*k].x2) * 61'(p_c);
    assign pq_s  = 62'(mn_s_q[k]) * 62'(SIN_RCP[k]);
    assign pq_c  = 62'(mn_c_q[k]) * 62'(COS_RCP[k]);
    assign r_s   = 31'(an_s_q[k]) - 31'(37'(aq_s_q[k]) * 37'(SIN_DIV[k]));
    assign r_c   = 31'(an_c_q[k]) - 31'(37'(aq_c_q[k]) * 37'(COS_DIV[k]));
    assign q_s   = aq_s_q[k] + 30'(r_s >= 31'(SIN_DIV[k]));
    assign q_c   = aq_c_q[k] + 30'(r_c >= 31'(COS_DIV[k]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mn_s_q[k] <= pm_s[59:30];
        mn_c_q[k] <= pm_c[59:30];
        an_s_q[k] <= mn_s_q[k];
        an_c_q[k] <= mn_c_q[k];
        aq_s_q[k] <= pq_s[61:32];
        aq_c_q[k] <= pq_c[61:32];
        bp_s_q[k] <= Q30_ONE - 31'(q_s);
        bp_c_q[k] <= Q30_ONE - 31'(q_c);
        bn_s_q[k] <= an_s_q[k];
      end
    end
  end

  // round, swap back from the folded octant, unfold the quadrant
  logic [31:0] rs_sum, rc_sum;
  logic [16:0] rs, rc, c0u, s0u;
  logic signed [17:0] c0, s0, cos_d, sin_d;

  assign rs_sum = 32'(bn_s_q[NSTEP-1]) + ROUND_Q16;
  assign rc_sum = 32'(bp_c_q[NSTEP-1]) + ROUND_Q16;
  assign rs     = rs_sum[30:14];
  assign rc     = rc_sum[30:14];
  assign c0u    = cx_q[NCX-1].swap ? rs : rc;
  assign s0u    = cx_q[NCX-1].swap ? rc : rs;
  assign c0     = $signed({1'b0, c0u});
  assign s0     = $signed({1'b0, s0u});

  always_comb begin
    unique case (cx_q[NCX-1].quad)
      2'd0: begin cos_d = c0;  sin_d = s0;  end
      2'd1: begin cos_d = -s0; sin_d = c0;  end
      2'd2: begin cos_d = -c0; sin_d = -s0; end
      default: begin cos_d = s0; sin_d = -c0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_d;
      sin_o <= sin_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/orot_back.sv
// ----------------------------------------------------------------------------
// orot_back: trig and separating axis evaluation
// Pop a word, run three trig pipelines, project on four axes, compare
// distance against summed extents and hold the verdict for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module orot_back #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned WW = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire orot_pkg::fifo_stat_t stat_i,
  input  wire logic [WW-1:0]        head_i,
  output      logic                 pop_o,
  input  wire logic                 out_ready_i,
  output      logic                 out_valid_o,
  output      logic                 overlap_o
);
  import orot_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned DXW = CW + 1;
  localparam int unsigned HW  = CW - 1;
  localparam int unsigned DW  = 2 * DXW + 4 * HW;
  localparam int unsigned PW  = CW + 19;
  localparam int unsigned SW  = CW + 20;
  localparam int unsigned EW  = CW + 16;
  localparam int unsigned LW  = CW + 18;

  logic en;
  logic [DW-1:0] h_dat;
  logic [ANGLE_WIDTH-1:0] h_aang, h_bang, h_dang;

  assign en    = !out_valid_o || out_ready_i;
  assign pop_o = en && !stat_i.empty;
  assign {h_dat, h_aang, h_bang, h_dang} = head_i;

  // trig pipelines with matching delay line
  logic signed [17:0] ca, sa, cb, sb, cd, sd;

  orot_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_a (
    .clk_i, .en_i(en), .angle_i(h_aang), .cos_o(ca), .sin_o(sa));
  orot_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_b (
    .clk_i, .en_i(en), .angle_i(h_bang), .cos_o(cb), .sin_o(sb));
  orot_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_d (
    .clk_i, .en_i(en), .angle_i(h_dang), .cos_o(cd), .sin_o(sd));

  logic          vld_q [TRIG_LAT];
  logic [DW-1:0] dat_q [TRIG_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TRIG_LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= pop_o;
      for (int i = 1; i < TRIG_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dat_q[0] <= h_dat;
      for (int i = 1; i < TRIG_LAT; i++) dat_q[i] <= dat_q[i-1];
    end
  end

  // products
  logic signed [DXW-1:0] dx, dy;
  logic [HW-1:0] ahw, ahh, bhw, bhh;
  logic [16:0]   cda, sda;

  assign {dx, dy, ahw, ahh, bhw, bhh} = dat_q[TRIG_LAT-1];
  assign cda = 17'(cd[17] ? -cd : cd);
  assign sda = 17'(sd[17] ? -sd : sd);

  logic signed [PW-1:0] pa0_q, pa1_q, pa2_q, pa3_q, pb0_q, pb1_q, pb2_q, pb3_q;
  logic [EW-1:0] e0_q, e1_q, e2_q, e3_q, e4_q, e5_q, e6_q, e7_q;
  logic [HW-1:0] ahw1_q, ahh1_q, bhw1_q, bhh1_q, ahw2_q, ahh2_q, bhw2_q, bhh2_q;
  logic          vld1_q, vld2_q, vld3_q, out_valid_q;

  // sums
  logic signed [SW-1:0] pj0_q, pj1_q, pj2_q, pj3_q;
  logic [EW:0] rb0_q, rb1_q, ra2_q, ra3_q;
  // magnitudes and limits
  logic [SW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic [LW-1:0] l0_q, l1_q, l2_q, l3_q;
  logic          ovl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa0_q <= PW'(dx) * PW'(ca);
      pa1_q <= PW'(dy) * PW'(sa);
      pa2_q <= PW'(dy) * PW'(ca);
      pa3_q <= PW'(dx) * PW'(sa);
      pb0_q <= PW'(dx) * PW'(cb);
      pb1_q <= PW'(dy) * PW'(sb);
      pb2_q <= PW'(dy) * PW'(cb);
      pb3_q <= PW'(dx) * PW'(sb);
      e0_q  <= EW'(bhw) * EW'(cda);
      e1_q  <= EW'(bhh) * EW'(sda);
      e2_q  <= EW'(bhw) * EW'(sda);
      e3_q  <= EW'(bhh) * EW'(cda);
      e4_q  <= EW'(ahw) * EW'(cda);
      e5_q  <= EW'(ahh) * EW'(sda);
      e6_q  <= EW'(ahw) * EW'(sda);
      e7_q  <= EW'(ahh) * EW'(cda);
      {ahw1_q, ahh1_q, bhw1_q, bhh1_q} <= {ahw, ahh, bhw, bhh};

      pj0_q <= SW'(pa0_q) + SW'(pa1_q);
      pj1_q <= SW'(pa2_q) - SW'(pa3_q);
      pj2_q <= SW'(pb0_q) + SW'(pb1_q);
      pj3_q <= SW'(pb2_q) - SW'(pb3_q);
      rb0_q <= (EW+1)'(e0_q) + (EW+1)'(e1_q);
      rb1_q <= (EW+1)'(e2_q) + (EW+1)'(e3_q);
      ra2_q <= (EW+1)'(e4_q) + (EW+1)'(e5_q);
      ra3_q <= (EW+1)'(e6_q) + (EW+1)'(e7_q);
      {ahw2_q, ahh2_q, bhw2_q, bhh2_q} <= {ahw1_q, ahh1_q, bhw1_q, bhh1_q};

      m0_q <= pj0_q[SW-1] ? SW'(-pj0_q) : SW'(pj0_q);
      m1_q <= pj1_q[SW-1] ? SW'(-pj1_q) : SW'(pj1_q);
      m2_q <= pj2_q[SW-1] ? SW'(-pj2_q) : SW'(pj2_q);
      m3_q <= pj3_q[SW-1] ? SW'(-pj3_q) : SW'(pj3_q);
      l0_q <= LW'({ahw2_q, 16'h0000}) + LW'(rb0_q);
      l1_q <= LW'({ahh2_q, 16'h0000}) + LW'(rb1_q);
      l2_q <= LW'({bhw2_q, 16'h0000}) + LW'(ra2_q);
      l3_q <= LW'({bhh2_q, 16'h0000}) + LW'(ra3_q);

      // touching counts as overlap
      ovl_q <= (m0_q <= SW'(l0_q)) && (m1_q <= SW'(l1_q)) &&
               (m2_q <= SW'(l2_q)) && (m3_q <= SW'(l3_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      vld3_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld1_q      <= vld_q[TRIG_LAT-1];
      vld2_q      <= vld1_q;
      vld3_q      <= vld2_q;
      out_valid_q <= vld3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign overlap_o   = ovl_q;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !stat_i.empty) else $error("pop from empty queue");
  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[TRIG_LAT-1] |-> (cd <= $signed(Q16_ONE) && cd >= -$signed(Q16_ONE)))
    else $error("cosine of angle difference out of range");
`endif

endmodule

`default_nettype wire

FILE: design/oriented_rect_overlap_test.sv
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test: 2D oriented rectangle overlap, separating axes
// Top level: front stage, word queue and evaluation back end.
// ----------------------------------------------------------------------------
// One rectangle pair enters per cycle while nothing stalls, and one overlap
// word leaves per pair, in order. Unstalled, a pair passes the front register,
// the queue, the trig pipelines (four Horner steps) and then the projection,
// summing, magnitude and compare registers. Throughput is one pair per clock
// while the output is not stalled, set by the fully pipelined trig and
// projection multipliers; the four-word queue lets the front keep
// accepting while the output word waits. Touching counts as overlap.
`default_nettype none

module oriented_rect_overlap_test #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] a_center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] a_center_y_i,
  input  wire logic        [COORD_WIDTH-2:0] a_half_w_i,
  input  wire logic        [COORD_WIDTH-2:0] a_half_h_i,
  input  wire logic        [ANGLE_WIDTH-1:0] a_angle_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_center_y_i,
  input  wire logic        [COORD_WIDTH-2:0] b_half_w_i,
  input  wire logic        [COORD_WIDTH-2:0] b_half_h_i,
  input  wire logic        [ANGLE_WIDTH-1:0] b_angle_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          overlap_o
);
  import orot_pkg::*;

  // queue word: centre differences, half sizes, both angles, angle difference
  localparam int unsigned WW = 2 * (COORD_WIDTH + 1) + 4 * (COORD_WIDTH - 1)
                             + 3 * ANGLE_WIDTH;

  fifo_stat_t    stat;
  logic          push, pop;
  logic [WW-1:0] push_word, head_word;

  // accept and form differences
  orot_front #(
    .COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH), .WW(WW)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .a_center_x_i, .a_center_y_i, .a_half_w_i, .a_half_h_i, .a_angle_i,
    .b_center_x_i, .b_center_y_i, .b_half_w_i, .b_half_h_i, .b_angle_i,
    .stat_i(stat), .push_o(push), .word_o(push_word)
  );

  // decouple: each side stalls on its own
  orot_fifo #(.W(WW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_word), .pop_i(pop),
    .data_o(head_word), .stat_o(stat)
  );

  // trig, projections, compare, output word
  orot_back #(
    .COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH), .WW(WW)
  ) u_back (
    .clk_i, .rst_ni, .stat_i(stat), .head_i(head_word), .pop_o(pop),
    .out_ready_i, .out_valid_o, .overlap_o
  );

endmodule

`default_nettype wire

FILE: tb/oriented_rect_overlap_test_test.sv
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test_test: self-checking bench for the rectangle overlap test
// Drives rectangle pairs through a valid/ready word channel and checks each overlap
// word against a local separating-axis predictor, under idle and stall phases.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_rect_overlap_test_test;

  localparam int CW = 24;
  localparam int AW = 16;
  localparam int PIPE_LAT = 22;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 400;

  typedef struct {
    logic signed [CW-1:0] ax, ay, bx, by;
    logic [CW-2:0] ahw, ahh, bhw, bhh;
    logic [AW-1:0] aang, bang;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] a_center_x_i = '0, a_center_y_i = '0;
  logic signed [CW-1:0] b_center_x_i = '0, b_center_y_i = '0;
  logic [CW-2:0] a_half_w_i = '0, a_half_h_i = '0, b_half_w_i = '0, b_half_h_i = '0;
  logic [AW-1:0] a_angle_i = '0, b_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic overlap_o;

  oriented_rect_overlap_test #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .a_center_x_i, .a_center_y_i, .a_half_w_i, .a_half_h_i, .a_angle_i,
    .b_center_x_i, .b_center_y_i, .b_half_w_i, .b_half_h_i, .b_angle_i,
    .out_valid_o, .out_ready_i, .overlap_o
  );

  always #5 clk_i = ~clk_i;

  pair_t pending_pairs[$];
  bit    expected_overlaps[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    recv_hold = 0;
  int    hold_cycles = 0;
  int    n_fail = 0;
  int    n_checked = 0;
  int    n_hit = 0;
  int    quiet_cycles = 0;

  // append a pair to the tail of the pending queue
  task automatic add_pair(input pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // Taylor cos/sin of an octant offset, Q16.
  function automatic void octant_cos_sin(input longint unsigned t,
                                         output longint c, output longint s);
    longint unsigned x, x2, p;
    x  = (t * 64'd1686629713) >> (AW - 2);
    x2 = (x * x) >> 30;
    p = (64'd1 << 30) - x2 / 42;
    p = (64'd1 << 30) - ((x2 * p) >> 30) / 20;
    p = (64'd1 << 30) - ((x2 * p) >> 30) / 6;
    s = longint'((((x * p) >> 30) + 64'd8192) >> 14);
    p = (64'd1 << 30) - x2 / 56;
    p = (64'd1 << 30) - ((x2 * p) >> 30) / 30;
    p = (64'd1 << 30) - ((x2 * p) >> 30) / 12;
    p = (64'd1 << 30) - ((x2 * p) >> 30) / 2;
    c = longint'((p + 64'd8192) >> 14);
  endfunction

  function automatic void angle_cos_sin(input logic [AW-1:0] ang,
                                        output longint c, output longint s);
    longint unsigned quarter, r;
    longint c0, s0;
    logic [1:0] quad;
    quarter = 64'd1 << (AW - 2);
    quad = ang[AW-1:AW-2];
    r = ang[AW-3:0];
    // fold the upper octant onto the lower one with cos and sin swapped
    if (r <= (quarter >> 1)) octant_cos_sin(r, c0, s0);
    else octant_cos_sin(quarter - r, s0, c0);
    case (quad)
      2'd0: begin c = c0;  s = s0;  end
      2'd1: begin c = -s0; s = c0;  end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit rects_overlap(input pair_t p);
    longint ca, sa, cb, sb, cd, sd, dx, dy, ahw, ahh, bhw, bhh;
    longint proj[4], ext[4];
    bit hit;
    ahw = p.ahw; ahh = p.ahh; bhw = p.bhw; bhh = p.bhh;
    angle_cos_sin(p.aang, ca, sa);
    angle_cos_sin(p.bang, cb, sb);
    angle_cos_sin(p.bang - p.aang, cd, sd);
    cd = mag(cd);
    sd = mag(sd);
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    proj[0] = dx * ca + dy * sa;
    ext[0]  = ahw * 65536 + bhw * cd + bhh * sd;
    proj[1] = dy * ca - dx * sa;
    ext[1]  = ahh * 65536 + bhw * sd + bhh * cd;
    proj[2] = dx * cb + dy * sb;
    ext[2]  = ahw * cd + ahh * sd + bhw * 65536;
    proj[3] = dy * cb - dx * sb;
    ext[3]  = ahw * sd + ahh * cd + bhh * 65536;
    hit = 1'b1;
    for (int i = 0; i < 4; i++) if (mag(proj[i]) > ext[i]) hit = 1'b0;
    return hit;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($urandom_range(4095)) - CW'(2048);
      default: return CW'($urandom_range(40000)) - CW'(20000);
    endcase
  endfunction

  function automatic logic [CW-2:0] rand_half();
    case ($urandom_range(4))
      0: return (CW-1)'($urandom);
      1: return '0;
      default: return (CW-1)'($urandom_range(12000));
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    case ($urandom_range(4))
      0: return AW'($urandom_range(3)) << (AW - 2);
      1: return AW'($urandom_range(7)) << (AW - 3);
      default: return AW'($urandom);
    endcase
  endfunction

  function automatic pair_t make_pair(logic [CW-1:0] ax, logic [CW-1:0] ay,
      logic [CW-2:0] ahw, logic [CW-2:0] ahh, logic [AW-1:0] aang,
      logic [CW-1:0] bx, logic [CW-1:0] by,
      logic [CW-2:0] bhw, logic [CW-2:0] bhh, logic [AW-1:0] bang);
    pair_t p;
    p.ax = ax; p.ay = ay; p.ahw = ahw; p.ahh = ahh; p.aang = aang;
    p.bx = bx; p.by = by; p.bhw = bhw; p.bhh = bhh; p.bang = bang;
    return p;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p = make_pair(rand_coord(), rand_coord(), rand_half(), rand_half(), rand_angle(),
                  rand_coord(), rand_coord(), rand_half(), rand_half(), rand_angle());
    // pull B near A half the time so both verdicts show up
    if ($urandom_range(1)) begin
      p.bx = p.ax + CW'($urandom_range(30000)) - CW'(15000);
      p.by = p.ay + CW'($urandom_range(30000)) - CW'(15000);
    end
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid_i || expected_overlaps.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: present the head of the queue, hold it until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_overlaps.insert(expected_overlaps.size(),
                                 rects_overlap(pending_pairs.pop_front()));
      end
      if ((!in_valid_i || in_ready_o) && pending_pairs.size() != 0
          && (in_valid_i && in_ready_o ? pending_pairs.size() != 0 : 1'b1)
          && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i   <= 1'b1;
        a_center_x_i <= pending_pairs[0].ax;
        a_center_y_i <= pending_pairs[0].ay;
        a_half_w_i   <= pending_pairs[0].ahw;
        a_half_h_i   <= pending_pairs[0].ahh;
        a_angle_i    <= pending_pairs[0].aang;
        b_center_x_i <= pending_pairs[0].bx;
        b_center_y_i <= pending_pairs[0].by;
        b_half_w_i   <= pending_pairs[0].bhw;
        b_half_h_i   <= pending_pairs[0].bhh;
        b_angle_i    <= pending_pairs[0].bang;
      end else if (in_valid_i && in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each overlap word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_overlaps.size() == 0) begin
          $error("overlap word with no prediction pending: %0b", overlap_o);
          n_fail++;
        end else begin
          bit exp_hit;
          exp_hit = expected_overlaps.pop_front();
          if (overlap_o !== exp_hit) begin
            $error("overlap mismatch: expected %0b actual %0b", exp_hit, overlap_o);
            n_fail++;
          end
          n_checked++;
          n_hit += exp_hit;
        end
      end
      // count down a long receiver hold-off in this process
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: drop the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
      $display("oriented_rect_overlap_test test failed");
      $finish;
    end
  end

  initial begin
    logic [CW-1:0] cmax, cmin;
    logic [CW-2:0] hmax;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    hmax = '1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero size, exact touching, aligned and rotated.
    add_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_pair(make_pair(cmax, cmax, hmax, hmax, '1, cmin, cmin, hmax, hmax, '1));
    add_pair(make_pair(cmin, cmin, 0, 0, 0, cmax, cmax, 0, 0, 0));
    add_pair(make_pair(cmax, cmin, 0, hmax, 16'h4000, cmin, cmax, hmax, 0, 16'hC000));
    add_pair(make_pair(0, 0, 256, 256, 0, 512, 0, 256, 256, 0));
    add_pair(make_pair(0, 0, 256, 256, 0, 513, 0, 256, 256, 0));
    add_pair(make_pair(0, 0, 256, 256, 0, 0, -512, 256, 256, 16'h8000));
    add_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h2000));
    add_pair(make_pair(0, 0, 0, 0, 0, 300, 0, 300, 0, 0));
    add_pair(make_pair(0, 0, 0, 0, 0, 301, 0, 300, 0, 0));
    add_pair(make_pair(0, 0, 1000, 100, 16'h2000, 700, 700, 1000, 100, 16'h2000));
    add_pair(make_pair(0, 0, 1000, 100, 16'h2000, 700, -700, 100, 100, 16'h6000));
    add_pair(make_pair(100, -100, 500, 500, 16'h1FFF, -400, 400, 300, 300, 16'h2001));
    add_pair(make_pair(0, 0, 400, 400, 16'hE000, 900, 0, 400, 400, 16'h1000));
    add_pair(make_pair(0, 0, 400, 400, 16'hFFFF, 0, 800, 400, 400, 16'h0001));
    add_pair(make_pair(0, 0, 1, 1, 16'h5555, 0, 0, hmax, hmax, 16'hAAAA));
    wait_drained();

    // Random phases: free flow, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 23 : 0;
      recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 23 : 0;
      for (int i = 0; i < N_RANDOM / 4; i++) add_pair(rand_pair());
      wait_drained();
    end

    // Back-pressure: hold the receiver off while the sender keeps offering.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_cycles <= 200;
    for (int i = 0; i < 40; i++) add_pair(rand_pair());
    wait_drained();

    repeat (PIPE_LAT + 10) @(posedge clk_i);
    $display("checked %0d overlap words (%0d overlapping, %0d separated)",
             n_checked, n_hit, n_checked - n_hit);
    $display("covered aligned, rotated, zero-size and touching pairs under idle phases");
    if (n_fail == 0 && expected_overlaps.size() == 0) begin
      $display("oriented_rect_overlap_test test passed");
    end else begin
      $display("oriented_rect_overlap_test test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
